// File: src/point_in_box_table_search_assert.svh
`ifndef POINT_IN_BOX_TABLE_SEARCH_ASSERT_SVH
`define POINT_IN_BOX_TABLE_SEARCH_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define PIBTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define PIBTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pibts_pkg.sv
package pibts_pkg;

    localparam int DEF_MAX_BOXES = 16;
    localparam int COUNT_W       = 5;
    localparam int SLOT_W        = 4;
    localparam int KIND_W        = 16;
    localparam int BOUND_W       = 16;
    localparam int POINT_W       = 32;

    localparam logic [KIND_W-1:0] KIND_MATCH = 16'd1;

    typedef enum logic
    {
        FUNC_WRITE = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

    typedef struct packed
    {
        func_t                     func;
        logic [SLOT_W-1:0]         entry_index;
        logic [KIND_W-1:0]         entry_kind;
        logic signed [BOUND_W-1:0] entry_x_low;
        logic signed [BOUND_W-1:0] entry_x_high;
        logic signed [BOUND_W-1:0] entry_z_low;
        logic signed [BOUND_W-1:0] entry_z_high;
        logic signed [POINT_W-1:0] point_x;
        logic signed [POINT_W-1:0] point_z;
    } in_word_t;

    typedef struct packed
    {
        logic              hit;
        logic [SLOT_W-1:0] hit_index;
    } out_word_t;

    typedef struct packed
    {
        logic [KIND_W-1:0]         kind;
        logic signed [BOUND_W-1:0] x_low;
        logic signed [BOUND_W-1:0] x_high;
        logic signed [BOUND_W-1:0] z_low;
        logic signed [BOUND_W-1:0] z_high;
    } box_t;

    typedef struct packed
    {
        logic signed [POINT_W-1:0] x;
        logic signed [POINT_W-1:0] z;
    } point_t;

endpackage

// File: src/pibts_box_mem.sv
module pibts_box_mem #(
    parameter int MAX_BOXES = pibts_pkg::DEF_MAX_BOXES,
    parameter int ADDR_W    = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
    input  logic               clk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  pibts_pkg::box_t    wr_box,
    input  logic [ADDR_W-1:0]  rd_addr,
    output pibts_pkg::box_t    rd_box
);

    pibts_pkg::box_t mem [MAX_BOXES];
    pibts_pkg::box_t rd_box_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_box;
        end
        rd_box_reg <= mem[rd_addr];
    end

    assign rd_box = rd_box_reg;

endmodule

// File: src/pibts_match_unit.sv
module pibts_match_unit (
    input  pibts_pkg::box_t   box,
    input  pibts_pkg::point_t point,
    output logic              match
);

    logic signed [pibts_pkg::POINT_W-1:0] x_low;
    logic signed [pibts_pkg::POINT_W-1:0] x_high;
    logic signed [pibts_pkg::POINT_W-1:0] z_low;
    logic signed [pibts_pkg::POINT_W-1:0] z_high;

    // sign-extend bounds to point width
    assign x_low  = pibts_pkg::POINT_W'(box.x_low);
    assign x_high = pibts_pkg::POINT_W'(box.x_high);
    assign z_low  = pibts_pkg::POINT_W'(box.z_low);
    assign z_high = pibts_pkg::POINT_W'(box.z_high);

    assign match = (box.kind == pibts_pkg::KIND_MATCH)
                && (x_low < point.x) && (point.x < x_high)
                && (z_low < point.z) && (point.z < z_high);

endmodule

// File: src/point_in_box_table_search.sv
// point_in_box_table_search
//
// item channel (item_valid/item_ready/item): a write word (func 0) stores one
// box entry at entry_index in the same cycle it is taken and gives no result;
// slots at or above MAX_BOXES are ignored. a query word (func 1) scans entries
// 0 to min(box_count, MAX_BOXES)-1 and returns the first kind-1 box that holds
// the point strictly, on the result channel (result_valid/result_ready/result)
// cfg channel (cfg_valid/cfg_ready/cfg_data): writes box_count, always ready
// a query reads one entry at a time through the single table read port and
// shared compare unit, from entry 0 up to the first hit or the last entry;
// a zero count answers with a miss without a scan. a write is stored when taken
// throughput: one query at a time; item_ready is low while a scan runs
// the result sits in an output register, so a new item is taken while it
// waits; if the receiver stalls, a second finished result is parked and
// the block holds off input until the output register frees up
// reset: count returns to 0, control clears, table contents stay undefined
// until written
`include "point_in_box_table_search_assert.svh"

module point_in_box_table_search #(
    parameter int MAX_BOXES = pibts_pkg::DEF_MAX_BOXES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  pibts_pkg::in_word_t                 item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output pibts_pkg::out_word_t                result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pibts_pkg::COUNT_W-1:0]       cfg_data
);

    localparam int ADDR_W  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int LIM_W0  = $clog2(MAX_BOXES + 1);
    localparam int LIM_W   = (LIM_W0 > pibts_pkg::COUNT_W) ? LIM_W0 : pibts_pkg::COUNT_W;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } state_t;

    state_t                          state_reg;
    logic [pibts_pkg::COUNT_W-1:0]   count_reg;
    logic [ADDR_W-1:0]               idx_reg;
    pibts_pkg::point_t               point_reg;
    pibts_pkg::out_word_t            park_reg;
    logic                            out_valid_reg;
    pibts_pkg::out_word_t            out_reg;

    logic                            item_take;
    logic                            query_take;
    logic                            wr_en;
    pibts_pkg::box_t                 wr_box;
    logic [ADDR_W-1:0]               rd_addr;
    pibts_pkg::box_t                 rd_box;
    logic                            match;
    logic [LIM_W-1:0]                limit;
    logic [LIM_W-1:0]                idx_plus;
    logic                            last_entry;
    logic                            out_free;
    logic                            out_load;

    assign item_ready   = (state_reg == ST_IDLE);
    assign item_take    = item_valid && item_ready;
    assign query_take   = item_take && (item.func == pibts_pkg::FUNC_QUERY);
    assign cfg_ready    = 1'b1;
    assign out_free     = !out_valid_reg || result_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign limit = (LIM_W'(count_reg) > LIM_W'(MAX_BOXES)) ? LIM_W'(MAX_BOXES)
                                                           : LIM_W'(count_reg);
    assign idx_plus   = LIM_W'(idx_reg) + LIM_W'(1);
    assign last_entry = (idx_plus == limit);

    // output register takes a new word this cycle
    assign out_load = out_free
                   && ((query_take && (limit == '0))
                    || ((state_reg == ST_SCAN) && (match || last_entry))
                    || (state_reg == ST_HOLD));

    assign wr_en = item_take && (item.func == pibts_pkg::FUNC_WRITE)
                && (int'(item.entry_index) < MAX_BOXES);
    assign wr_box.kind   = item.entry_kind;
    assign wr_box.x_low  = item.entry_x_low;
    assign wr_box.x_high = item.entry_x_high;
    assign wr_box.z_low  = item.entry_z_low;
    assign wr_box.z_high = item.entry_z_high;

    // next entry to read: zero on a fresh query, one ahead while scanning
    assign rd_addr = (state_reg == ST_SCAN) ? ADDR_W'(idx_plus) : '0;

    pibts_box_mem #(
        .MAX_BOXES (MAX_BOXES),
        .ADDR_W    (ADDR_W)
    ) u_box_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(item.entry_index)),
        .wr_box  (wr_box),
        .rd_addr (rd_addr),
        .rd_box  (rd_box)
    );

    pibts_match_unit u_match_unit (
        .box   (rd_box),
        .point (point_reg),
        .match (match)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            point_reg     <= '0;
            park_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end

            if (out_valid_reg && result_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (query_take)
                    begin
                        point_reg.x <= item.point_x;
                        point_reg.z <= item.point_z;
                        idx_reg     <= '0;
                        if (limit == '0)
                        begin
                            // empty table search: miss right away
                            if (out_free)
                            begin
                                out_reg       <= '0;
                                out_valid_reg <= 1'b1;
                            end
                            else
                            begin
                                park_reg  <= '0;
                                state_reg <= ST_HOLD;
                            end
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (match || last_entry)
                    begin
                        if (out_free)
                        begin
                            out_reg.hit       <= match;
                            out_reg.hit_index <= match ? pibts_pkg::SLOT_W'(idx_reg) : '0;
                            out_valid_reg     <= 1'b1;
                            state_reg         <= ST_IDLE;
                        end
                        else
                        begin
                            park_reg.hit       <= match;
                            park_reg.hit_index <= match ? pibts_pkg::SLOT_W'(idx_reg) : '0;
                            state_reg          <= ST_HOLD;
                        end
                    end
                    else
                    begin
                        idx_reg <= ADDR_W'(idx_plus);
                    end
                end
                ST_HOLD:
                begin
                    if (out_free)
                    begin
                        out_reg       <= park_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `PIBTS_ASSERT_NOW(a_miss_index_zero,
        result_valid && !result.hit,
        result.hit_index == '0,
        "miss reported with nonzero index")

    `PIBTS_ASSERT_NOW(a_scan_in_range,
        state_reg == ST_SCAN,
        LIM_W'(idx_reg) < limit,
        "scan index past search limit")

    `PIBTS_ASSERT_NEXT(a_query_starts_work,
        query_take,
        state_reg != ST_IDLE || result_valid,
        "accepted query left no trace")

    `PIBTS_ASSERT_NEXT(a_hold_keeps_output,
        state_reg == ST_HOLD && !result_ready,
        result_valid,
        "parked result while output register empty")

endmodule
